// File: rtl/core/rcfd_pkg.sv
package rcfd_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDE_MODE     = 3'd0,
    CFG_CHANNEL_LIMIT = 3'd1,
    CFG_GAP_LIMIT     = 3'd2,
    CFG_TIMER_RELOAD  = 3'd3,
    CFG_AUX_THRESHOLD = 3'd4
  } rcfd_cfg_idx_t;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TIMER_W = 24;
  localparam int unsigned ID_W    = 4;
  localparam int unsigned VALUE_W = 11;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned WORD_W  = 2 * BYTE_W;
  localparam int unsigned GOOD_W  = 10;

  // Reset values of the configuration registers
  localparam logic                RST_WIDE_MODE     = 1'b1;
  localparam logic [ID_W-1:0]     RST_CHANNEL_LIMIT = 4'd12;
  localparam logic [TIMER_W-1:0]  RST_GAP_LIMIT     = 24'd5000;
  localparam logic [TIMER_W-1:0]  RST_TIMER_RELOAD  = 24'hFFFFFF;
  localparam logic [VALUE_W-1:0]  RST_AUX_THRESHOLD = 11'd1100;

  // Good-word counter thresholds
  localparam logic [GOOD_W-1:0] BIND_LIMIT = 10'd900;
  localparam logic [GOOD_W-1:0] GOOD_SAT   = 10'd901;

  // Words reported per frame never exceed this
  localparam int unsigned MAX_WORDS = 7;

  typedef struct packed {
    logic               wide_mode;
    logic [ID_W-1:0]    channel_limit;
    logic [TIMER_W-1:0] gap_limit;
    logic [TIMER_W-1:0] timer_reload;
    logic [VALUE_W-1:0] aux_threshold;
  } rcfd_cfg_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [ID_W-1:0]    channel_id;
    logic [VALUE_W-1:0] channel_value;
    logic               valid_res;
    logic               aux_on;
    logic               bind_indicator;
    logic               ready_res;
    logic               last;
  } rcfd_res_t;

endpackage

// File: rtl/core/rcfd_in_if.sv
interface rcfd_in_if;
  import rcfd_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  rx_byte;
  logic [TIMER_W-1:0] timer_now;

  modport source (output valid, output rx_byte, output timer_now, input ready);
  modport sink (input valid, input rx_byte, input timer_now, output ready);
endinterface

// File: rtl/core/rcfd_out_if.sv
interface rcfd_out_if;
  import rcfd_pkg::*;

  logic               valid;
  logic               ready;
  logic [SLOT_W-1:0]  slot;
  logic [ID_W-1:0]    channel_id;
  logic [VALUE_W-1:0] channel_value;
  logic               valid_res;
  logic               aux_on;
  logic               bind_indicator;
  logic               ready_res;
  logic               last;

  modport source (
    output valid, output slot, output channel_id, output channel_value,
    output valid_res, output aux_on, output bind_indicator, output ready_res,
    output last, input ready
  );
  modport sink (
    input valid, input slot, input channel_id, input channel_value,
    input valid_res, input aux_on, input bind_indicator, input ready_res,
    input last, output ready
  );
endinterface

// File: rtl/core/rcfd_cfg_if.sv
interface rcfd_cfg_if;
  import rcfd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/rc_serial_frame_channel_decoder_core.sv
// Serial RC frame channel decoder.
// in_ch: one transfer per received serial byte, with the down-counting timer
//   sample taken at its arrival. A byte whose gap from the previous one exceeds
//   gap_limit restarts the frame at position 0.
// out_ch: on the final byte of a frame, one transfer per 16-bit word from
//   byte 2 on (seven for a 16-byte frame), slot 0 first; last marks the final
//   word. Each word carries channel id, value, valid, aux and bind/ready status.
// cfg_ch: register writes (0 wide_mode, 1 channel_limit, 2 gap_limit,
//   3 timer_reload, 4 aux_threshold); always ready, other indexes are dropped.
// Order and flow: the front end accepts a byte whenever the frame queue is not
//   full. The first word of a frame passes through the frame queue entry and
//   then the output register; the rest follow one per cycle while the receiver
//   is ready.
// A two-entry frame queue parts front and back; the input stalls only while
//   both entries hold frames still being reported.
// Reset restores the register defaults, clears the frame position, timer
//   history and good-word counter. A stalled receiver holds the current word
//   in the output register; the back end waits and the queue fills.
module rc_serial_frame_channel_decoder_core #(
  parameter int unsigned FRAME_BYTES  = 16,
  parameter int unsigned MAX_CHANNELS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  rcfd_in_if.sink     in_ch,
  rcfd_out_if.source  out_ch,
  rcfd_cfg_if.sink    cfg_ch
);
  import rcfd_pkg::*;

  localparam int unsigned RAW_WORDS = (FRAME_BYTES - 2) / 2;
  localparam int unsigned NUM_WORDS = (RAW_WORDS > MAX_WORDS) ? MAX_WORDS : RAW_WORDS;
  localparam int unsigned Q_W       = NUM_WORDS * WORD_W;

  rcfd_cfg_t        cfg_r, cfg_nxt;
  logic             q_full, q_not_empty, q_pop, push;
  logic [Q_W-1:0]   push_data, head_data;
  rcfd_res_t        res;

  // Configuration registers: always ready, write masked to each width
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_WIDE_MODE:     cfg_nxt.wide_mode     = cfg_ch.data[0];
        CFG_CHANNEL_LIMIT: cfg_nxt.channel_limit = cfg_ch.data[ID_W-1:0];
        CFG_GAP_LIMIT:     cfg_nxt.gap_limit     = cfg_ch.data[TIMER_W-1:0];
        CFG_TIMER_RELOAD:  cfg_nxt.timer_reload  = cfg_ch.data[TIMER_W-1:0];
        CFG_AUX_THRESHOLD: cfg_nxt.aux_threshold = cfg_ch.data[VALUE_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wide_mode     <= RST_WIDE_MODE;
      cfg_r.channel_limit <= RST_CHANNEL_LIMIT;
      cfg_r.gap_limit     <= RST_GAP_LIMIT;
      cfg_r.timer_reload  <= RST_TIMER_RELOAD;
      cfg_r.aux_threshold <= RST_AUX_THRESHOLD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: gap check, byte placement, frame snapshot
  rcfd_front #(
    .FRAME_BYTES (FRAME_BYTES),
    .NUM_WORDS   (NUM_WORDS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .rx_byte   (in_ch.rx_byte),
    .timer_now (in_ch.timer_now),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // Completed frames wait here for the word decoder
  rcfd_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_data (head_data)
  );

  // Back end: one word per cycle into the output register while it is free or being taken
  rcfd_back #(
    .NUM_WORDS    (NUM_WORDS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_data      (head_data),
    .q_pop       (q_pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .res         (res)
  );

  assign out_ch.slot           = res.slot;
  assign out_ch.channel_id     = res.channel_id;
  assign out_ch.channel_value  = res.channel_value;
  assign out_ch.valid_res      = res.valid_res;
  assign out_ch.aux_on         = res.aux_on;
  assign out_ch.bind_indicator = res.bind_indicator;
  assign out_ch.ready_res      = res.ready_res;
  assign out_ch.last           = res.last;

endmodule

// File: rtl/core/rcfd_front.sv
module rcfd_front #(
  parameter int unsigned FRAME_BYTES = 16,
  parameter int unsigned NUM_WORDS   = 7
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rcfd_pkg::rcfd_cfg_t                 cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rcfd_pkg::BYTE_W-1:0]         rx_byte,
  input  logic [rcfd_pkg::TIMER_W-1:0]        timer_now,
  input  logic                                q_full,
  output logic                                push,
  output logic [NUM_WORDS*rcfd_pkg::WORD_W-1:0] push_data
);
  import rcfd_pkg::*;

  localparam int unsigned PW = $clog2(FRAME_BYTES);
  localparam logic [PW-1:0] LAST_POS = PW'(FRAME_BYTES - 1);

  logic [PW-1:0]      pos_r, pos_nxt;
  logic [TIMER_W-1:0] prev_r;
  logic [BYTE_W-1:0]  store_r [FRAME_BYTES];

  logic               accept;
  logic [TIMER_W:0]   wrap_gap;
  logic [TIMER_W:0]   gap;
  logic               new_frame;
  logic [PW-1:0]      wr_idx;
  logic               frame_done;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Down-counting timer: equal samples count as one full reload
  always_comb begin
    wrap_gap = {1'b0, prev_r} + {1'b0, cfg.timer_reload} - {1'b0, timer_now};
    if (timer_now < prev_r) begin
      gap = {1'b0, prev_r - timer_now};
    end else begin
      gap = wrap_gap;
    end
    new_frame = gap > {1'b0, cfg.gap_limit};
  end

  assign wr_idx     = new_frame ? '0 : pos_r;
  assign frame_done = (wr_idx == LAST_POS);
  assign pos_nxt    = frame_done ? '0 : wr_idx + PW'(1);
  assign push       = accept && frame_done;

  // Snapshot of the word bytes; the final byte arrives in this transfer
  always_comb begin
    for (int w = 0; w < NUM_WORDS; w++) begin
      if (2 * w + 2 == FRAME_BYTES - 1) begin
        push_data[w*WORD_W + BYTE_W +: BYTE_W] = rx_byte;
      end else begin
        push_data[w*WORD_W + BYTE_W +: BYTE_W] = store_r[2 * w + 2];
      end
      if (2 * w + 3 == FRAME_BYTES - 1) begin
        push_data[w*WORD_W +: BYTE_W] = rx_byte;
      end else begin
        push_data[w*WORD_W +: BYTE_W] = store_r[2 * w + 3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      prev_r <= '0;
    end else if (accept) begin
      pos_r  <= pos_nxt;
      prev_r <= timer_now;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      store_r[wr_idx] <= rx_byte;
    end
  end

endmodule

// File: rtl/core/rcfd_queue.sv
module rcfd_queue #(
  parameter int unsigned WIDTH = 112
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output logic [WIDTH-1:0] head_data
);

  logic [WIDTH-1:0] data_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head_data = data_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/core/rcfd_back.sv
module rcfd_back #(
  parameter int unsigned NUM_WORDS    = 7,
  parameter int unsigned MAX_CHANNELS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  rcfd_pkg::rcfd_cfg_t                   cfg,
  input  logic                                  q_not_empty,
  input  logic [NUM_WORDS*rcfd_pkg::WORD_W-1:0] q_data,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output rcfd_pkg::rcfd_res_t                   res
);
  import rcfd_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_WORDS - 1);
  localparam logic [ID_W:0]     CHAN_MAX  = (ID_W + 1)'(MAX_CHANNELS);

  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [GOOD_W-1:0] good_r, good_nxt;
  logic              rdy_r, rdy_nxt;
  logic              out_valid_r, out_valid_nxt;
  rcfd_res_t         res_r, res_nxt;

  logic              load;
  logic [WORD_W-1:0] word;
  logic [BYTE_W-1:0] hi, lo;
  logic [ID_W-1:0]   id;
  logic [VALUE_W-1:0] value;
  logic              id_ok;
  logic [GOOD_W-1:0] good_inc;

  assign load  = q_not_empty && (!out_valid_r || out_ready);
  assign q_pop = load && (slot_r == LAST_SLOT);

  assign word = q_data[slot_r*WORD_W +: WORD_W];
  assign hi   = word[WORD_W-1:BYTE_W];
  assign lo   = word[BYTE_W-1:0];

  always_comb begin
    if (cfg.wide_mode) begin
      id    = hi[6:3];
      value = {hi[2:0], lo};
    end else begin
      id    = hi[5:2];
      value = {1'b0, hi[1:0], lo};
    end
    id_ok    = (id < cfg.channel_limit) && ({1'b0, id} < CHAN_MAX);
    good_inc = good_r + GOOD_W'(1);
  end

  // Saturating good-word counter; ready sticks once the count passes the limit
  always_comb begin
    good_nxt = good_r;
    rdy_nxt  = rdy_r;
    if (load && id_ok) begin
      if (good_inc > BIND_LIMIT) begin
        good_nxt = GOOD_SAT;
        rdy_nxt  = 1'b1;
      end else begin
        good_nxt = good_inc;
      end
    end
  end

  always_comb begin
    res_nxt.slot           = slot_r;
    res_nxt.channel_id     = id;
    res_nxt.channel_value  = value;
    res_nxt.valid_res      = id_ok;
    res_nxt.aux_on         = value > cfg.aux_threshold;
    res_nxt.bind_indicator = (good_nxt != '0) && (good_nxt < BIND_LIMIT);
    res_nxt.ready_res      = rdy_nxt;
    res_nxt.last           = (slot_r == LAST_SLOT);
  end

  always_comb begin
    slot_nxt = slot_r;
    if (load) begin
      slot_nxt = (slot_r == LAST_SLOT) ? '0 : slot_r + SLOT_W'(1);
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      good_r      <= '0;
      rdy_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      slot_r      <= slot_nxt;
      good_r      <= good_nxt;
      rdy_r       <= rdy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

// File: tb/sv/rcfd_word_check_pkg.sv
package rcfd_word_check_pkg;
  import rcfd_pkg::*;

  localparam int unsigned FRAME_LEN   = 16;
  localparam int unsigned CHANNEL_CAP = 12;
  localparam int unsigned FRAME_WORDS =
    ((FRAME_LEN - 2) / 2 > MAX_WORDS) ? MAX_WORDS : (FRAME_LEN - 2) / 2;

  // Tracks the decoder state and holds the words each frame should produce.
  class rc_word_predictor;
    rcfd_cfg_t          cfg;
    int unsigned        byte_pos;
    logic [TIMER_W-1:0] prev_timer;
    logic [BYTE_W-1:0]  frame_buf [FRAME_LEN];
    int unsigned        good_count;
    logic               link_ready;
    rcfd_res_t          expected_words [$];
    int unsigned        errors;

    function new();
      cfg.wide_mode     = RST_WIDE_MODE;
      cfg.channel_limit = RST_CHANNEL_LIMIT;
      cfg.gap_limit     = RST_GAP_LIMIT;
      cfg.timer_reload  = RST_TIMER_RELOAD;
      cfg.aux_threshold = RST_AUX_THRESHOLD;
      byte_pos   = 0;
      prev_timer = '0;
      good_count = 0;
      link_ready = 1'b0;
      errors     = 0;
    endfunction

    function void set_reg(rcfd_cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_WIDE_MODE:     cfg.wide_mode     = val[0];
        CFG_CHANNEL_LIMIT: cfg.channel_limit = val[ID_W-1:0];
        CFG_GAP_LIMIT:     cfg.gap_limit     = val[TIMER_W-1:0];
        CFG_TIMER_RELOAD:  cfg.timer_reload  = val[TIMER_W-1:0];
        CFG_AUX_THRESHOLD: cfg.aux_threshold = val[VALUE_W-1:0];
        default: ;
      endcase
    endfunction

    // Note one accepted byte; on the final byte of a frame queue its words.
    function void take_byte(logic [BYTE_W-1:0] rx, logic [TIMER_W-1:0] now);
      logic [TIMER_W:0]   gap;
      logic [BYTE_W-1:0]  hi;
      logic [BYTE_W-1:0]  lo;
      logic [ID_W-1:0]    id;
      logic [VALUE_W-1:0] val;
      logic               ok;
      rcfd_res_t          word;
      // Down-counting timer: equal samples count as a full reload, sum wraps at 25 bits
      if (now < prev_timer)
        gap = {1'b0, prev_timer - now};
      else
        gap = {1'b0, prev_timer} + {1'b0, cfg.timer_reload} - {1'b0, now};
      prev_timer = now;
      if (gap > {1'b0, cfg.gap_limit})
        byte_pos = 0;
      frame_buf[byte_pos] = rx;
      byte_pos++;
      if (byte_pos < FRAME_LEN)
        return;
      byte_pos = 0;
      for (int w = 0; w < FRAME_WORDS; w++) begin
        hi = frame_buf[2 * w + 2];
        lo = frame_buf[2 * w + 3];
        if (cfg.wide_mode) begin
          id  = hi[6:3];
          val = {hi[2:0], lo};
        end else begin
          id  = hi[5:2];
          val = {1'b0, hi[1:0], lo};
        end
        ok = (id < cfg.channel_limit) && (id < CHANNEL_CAP);
        if (ok) begin
          good_count++;
          if (good_count > BIND_LIMIT) begin
            link_ready = 1'b1;
            good_count = GOOD_SAT;
          end
        end
        word.slot           = SLOT_W'(w);
        word.channel_id     = id;
        word.channel_value  = val;
        word.valid_res      = ok;
        word.aux_on         = val > cfg.aux_threshold;
        word.bind_indicator = (good_count > 0) && (good_count < BIND_LIMIT);
        word.ready_res      = link_ready;
        word.last           = (w == FRAME_WORDS - 1);
        expected_words.push_back(word);
      end
    endfunction

    function void cmp_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_word(rcfd_res_t got);
      rcfd_res_t want;
      if (expected_words.size() == 0) begin
        $error("word with no frame behind it: slot %0d id %0d", got.slot, got.channel_id);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      cmp_field("slot",           want.slot,           got.slot);
      cmp_field("channel_id",     want.channel_id,     got.channel_id);
      cmp_field("channel_value",  want.channel_value,  got.channel_value);
      cmp_field("valid_res",      want.valid_res,      got.valid_res);
      cmp_field("aux_on",         want.aux_on,         got.aux_on);
      cmp_field("bind_indicator", want.bind_indicator, got.bind_indicator);
      cmp_field("ready_res",      want.ready_res,      got.ready_res);
      cmp_field("last",           want.last,           got.last);
    endfunction
  endclass

endpackage

// File: tb/sv/testbench.sv
module testbench;
  import rcfd_pkg::*;
  import rcfd_word_check_pkg::*;

  logic clk;
  logic rst_n;

  rcfd_in_if  in_ch();
  rcfd_out_if out_ch();
  rcfd_cfg_if cfg_ch();

  rc_word_predictor word_pred = new();

  int unsigned sent_bytes;    // byte transfers so far, paces the random traffic
  int unsigned hold_request;  // long receiver hold-off, picked up by the receiver
  bit          calm;          // suppress idling on both sides

  rc_serial_frame_channel_decoder_core #(
    .FRAME_BYTES (FRAME_LEN),
    .MAX_CHANNELS(CHANNEL_CAP)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int unsigned pick_idle();
    int unsigned r;
    if (calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Inter-byte gap that keeps a frame together; now and then exactly the limit.
  function automatic int unsigned step_gap(int unsigned max_step);
    int unsigned lim;
    int unsigned hi;
    lim = word_pred.cfg.gap_limit;
    if ($urandom_range(0, 19) == 0)
      return lim;
    hi = (lim < max_step) ? lim : max_step;
    if (hi == 0)
      return 0;
    return $urandom_range(1, hi);
  endfunction

  // Timer sample that yields a gap of d ticks from the last accepted byte.
  // Where d cannot be reached, fall back to an equal sample (gap = reload < d).
  function automatic logic [TIMER_W-1:0] next_timer(int unsigned d);
    logic [TIMER_W:0] prev;
    logic [TIMER_W:0] reload;
    logic [TIMER_W:0] dd;
    prev   = word_pred.prev_timer;
    reload = word_pred.cfg.timer_reload;
    dd     = d;
    if (dd != 0 && dd <= prev)
      return TIMER_W'(prev - dd);
    if (dd <= reload)
      return TIMER_W'(prev + reload - dd);
    return TIMER_W'(prev);
  endfunction

  // Timer sample meant to push the gap over the limit and restart the frame:
  // an equal sample, a plain long gap, or a sample past prev + reload (wrap).
  function automatic logic [TIMER_W-1:0] restart_timer();
    logic [TIMER_W:0] prev;
    logic [TIMER_W:0] reload;
    logic [TIMER_W:0] lim;
    prev   = word_pred.prev_timer;
    reload = word_pred.cfg.timer_reload;
    lim    = word_pred.cfg.gap_limit;
    if (lim < reload && $urandom_range(0, 1) == 0)
      return TIMER_W'(prev);
    if (lim + 1 <= prev)
      return TIMER_W'(prev - lim - 1);
    if (prev + reload < {1'b0, {TIMER_W{1'b1}}})
      return TIMER_W'(prev + reload + 1);
    if (lim < reload)
      return TIMER_W'(prev);
    return TIMER_W'($urandom);
  endfunction

  // Frame content by position; high bytes of words may carry an accepted id.
  function automatic logic [BYTE_W-1:0] frame_byte(int unsigned pos, bit valid_ids);
    logic [BYTE_W-1:0] b;
    logic [ID_W-1:0]   id;
    b = BYTE_W'($urandom);
    if (valid_ids && pos >= 2 && pos % 2 == 0 && word_pred.cfg.channel_limit != 0) begin
      id = ID_W'($urandom_range(0, word_pred.cfg.channel_limit - 1));
      if (word_pred.cfg.wide_mode)
        b[6:3] = id;
      else
        b[5:2] = id;
    end
    return b;
  endfunction

  // Offer one byte and hold it until the transfer; record it at that edge.
  task automatic send_byte(logic [BYTE_W-1:0] b, logic [TIMER_W-1:0] now, bit gapless);
    int unsigned idle;
    idle = gapless ? 0 : pick_idle();
    if (idle != 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.rx_byte   <= b;
    in_ch.timer_now <= now;
    do @(posedge clk); while (!in_ch.ready);
    word_pred.take_byte(b, now);
    sent_bytes++;
  endtask

  // Start a frame with a restart attempt, then fill positions until the frame
  // completes; a nonzero cut drops the frame after that many bytes.
  task automatic send_frame(int unsigned cut, bit gapless, bit valid_ids,
                            int unsigned max_step);
    int unsigned n;
    send_byte(frame_byte(0, valid_ids), restart_timer(), gapless);
    n = 1;
    while (word_pred.byte_pos != 0 && (cut == 0 || n < cut) && n < 4 * FRAME_LEN) begin
      send_byte(frame_byte(word_pred.byte_pos, valid_ids), next_timer(step_gap(max_step)),
                gapless);
      n++;
    end
  endtask

  // Mix of whole frames, broken frames and stray bytes at random times.
  task automatic random_traffic(int unsigned count);
    int unsigned target;
    int unsigned r;
    target = sent_bytes + count;
    while (sent_bytes < target) begin
      r = $urandom_range(0, 9);
      if (r < 7)
        send_frame(0, 1'b0, $urandom_range(0, 1), 300);
      else if (r < 9)
        send_frame($urandom_range(2, FRAME_LEN - 1), 1'b0, 1'b0, 300);
      else
        repeat ($urandom_range(1, 4))
          send_byte(BYTE_W'($urandom), TIMER_W'($urandom), 1'b0);
    end
  endtask

  // Drop valid, let every expected word out, then let the front end settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (word_pred.expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Write all five registers back to back; call only while the block is idle.
  task automatic set_config(int unsigned wm, int unsigned cl, int unsigned gl,
                            int unsigned tr, int unsigned at);
    rcfd_cfg_idx_t         idx [5];
    logic [CFG_DATA_W-1:0] val [5];
    idx = '{CFG_WIDE_MODE, CFG_CHANNEL_LIMIT, CFG_GAP_LIMIT, CFG_TIMER_RELOAD,
            CFG_AUX_THRESHOLD};
    val = '{CFG_DATA_W'(wm), CFG_DATA_W'(cl), CFG_DATA_W'(gl), CFG_DATA_W'(tr),
            CFG_DATA_W'(at)};
    for (int i = 0; i < 5; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= val[i];
      do @(posedge clk); while (!cfg_ch.ready);
      word_pred.set_reg(idx[i], val[i]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Receiver: check every word transfer, then decide ready for the next edge.
  // A hold request from the stimulus side holds the output's ready low until its count runs out.
  initial begin
    int unsigned stall_left;
    rcfd_res_t   got;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.slot           = out_ch.slot;
        got.channel_id     = out_ch.channel_id;
        got.channel_value  = out_ch.channel_value;
        got.valid_res      = out_ch.valid_res;
        got.aux_on         = out_ch.aux_on;
        got.bind_indicator = out_ch.bind_indicator;
        got.ready_res      = out_ch.ready_res;
        got.last           = out_ch.last;
        word_pred.check_word(got);
      end
      if (hold_request != 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0)
          stall_left = pick_idle();
      end
    end
  end

  // Stimulus
  initial begin
    logic [BYTE_W-1:0] dir_frame [FRAME_LEN];
    in_ch.valid     = 1'b0;
    in_ch.rx_byte   = '0;
    in_ch.timer_now = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CFG_WIDE_MODE;
    cfg_ch.data     = '0;
    rst_n           = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frame at reset settings (11-bit mode, limit 12, aux 1100).
    // Words: id 0 value 0; id 15 value 2047; id 11 at the aux threshold;
    // id 12 (just past the limit) one above it; id 1 / 7 / 3 ordinary.
    dir_frame = '{8'h55, 8'hAA, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h5C, 8'h4C,
                  8'h64, 8'h4D, 8'h08, 8'hFF, 8'h3B, 8'h00, 8'h1F, 8'h80};
    // Open with an equal timer sample: counts as a full reload, so restart.
    send_byte(dir_frame[0], word_pred.prev_timer, 1'b0);
    for (int i = 1; i < FRAME_LEN; i++)
      send_byte(dir_frame[i], next_timer(i == 8 ? word_pred.cfg.gap_limit
                                                : $urandom_range(1, 200)), 1'b0);
    // One tick over the gap limit restarts, then the field extremes.
    send_byte(8'hC3, next_timer(word_pred.cfg.gap_limit + 1), 1'b0);
    send_byte(8'hFF, {TIMER_W{1'b1}}, 1'b0);
    send_byte(8'h00, '0, 1'b0);

    // Backpressure: hold the receiver off while full frames keep coming, so
    // the frame queue fills and the input stalls.
    hold_request = 300;
    repeat (3) send_frame(0, 1'b1, 1'b1, 200);
    drain();

    // Low extremes: 10-bit mode, only id 0 accepted, zero gap limit and
    // reload (only equal samples keep a frame together), aux threshold 0.
    set_config(0, 1, 0, 0, 0);
    random_traffic(15);
    drain();

    // High extremes, with no idling on either side.
    calm = 1'b1;
    set_config(1, CHANNEL_CAP, 24'hFFFFFF, 24'hFFFFFF, 2047);
    random_traffic(15);
    calm = 1'b0;
    drain();

    // Random settings; the middle pass uses a short reload so that samples
    // land past prev + reload and the gap wraps.
    for (int k = 0; k < 3; k++) begin
      set_config($urandom_range(0, 1), $urandom_range(1, CHANNEL_CAP),
                 $urandom_range(100, 20000),
                 (k == 1) ? $urandom_range(0, 3000) : $urandom_range(0, 24'hFFFFFF),
                 $urandom_range(0, 2047));
      random_traffic(10);
      drain();
    end

    if (word_pred.errors == 0)
      $display("rc_serial_frame_channel_decoder_core test passed");
    else
      $display("rc_serial_frame_channel_decoder_core test failed");
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("rc_serial_frame_channel_decoder_core test failed");
    $finish;
  end

endmodule
